/* rtl/rebq_pkg.sv */
// shared types, constants and helpers of the rotary encoder and button qualifier
// no dependencies
`default_nettype none

package rebq_pkg;

   localparam int TimeWidth   = 32;
   localparam int StampWidth  = 23;
   localparam int MinPressWidth = 16;
   localparam int CsrAddrWidth  = 4;
   localparam int CsrDataWidth  = 32;

   // divide by 1000 as multiply by ceil(2^38 / 1000) then shift by 38
   localparam int MsShift      = 38;
   localparam int MsRecipWidth = 29;
   localparam logic [MsRecipWidth-1:0] MS_RECIP = 29'd274877907;
   localparam int MsProdWidth  = TimeWidth + MsRecipWidth;

   localparam logic [TimeWidth-1:0] DEFAULT_LONG_PRESS_MS = 32'd500;
   localparam logic [TimeWidth-1:0] RESET_LONG_PRESS_MS   = 32'd500;
   localparam logic [TimeWidth-1:0] RESET_ROTARY_LOCKOUT  = 32'd10000;
   localparam logic [TimeWidth-1:0] RESET_BUTTON_LOCKOUT  = 32'd50000;
   localparam logic [MinPressWidth-1:0] RESET_MIN_PRESS_MS = 16'd50;
   localparam logic [1:0] RESET_QUADRATURE = 2'b11;

   typedef enum logic [1:0] {
      REG_LONG_PRESS     = 2'd0,
      REG_ROTARY_LOCKOUT = 2'd1,
      REG_BUTTON_LOCKOUT = 2'd2,
      REG_MIN_PRESS      = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      KIND_CW    = 2'd0,
      KIND_CCW   = 2'd1,
      KIND_PRESS = 2'd2,
      KIND_BACK  = 2'd3
   } event_kind_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_BWD  = 2'd2
   } step_dir_type;

   localparam logic MODE_ROTARY = 1'b0;
   localparam logic MODE_BUTTON = 1'b1;

   typedef struct packed {
      logic                 mode;
      logic                 level_a;
      logic                 level_b;
      logic                 level_button;
      logic [TimeWidth-1:0] time_us;
   } req_item_type;

   typedef struct packed {
      logic [1:0]            event_kind;
      logic [StampWidth-1:0] stamp_ms;
   } rsp_item_type;

   typedef struct packed {
      logic [TimeWidth-1:0]     back_hold_ms;
      logic [TimeWidth-1:0]     rotary_lockout_us;
      logic [TimeWidth-1:0]     button_lockout_us;
      logic [MinPressWidth-1:0] min_press_ms;
   } cfg_type;

   // gray code step direction from old to new quadrature state
   function automatic step_dir_type step_dir(input logic [1:0] from_q, input logic [1:0] to_q);
      step_dir_type dir;
      case ({from_q, to_q})
         4'b0001, 4'b0111, 4'b1000, 4'b1110: dir = DIR_FWD;
         4'b0010, 4'b0100, 4'b1011, 4'b1101: dir = DIR_BWD;
         default:                            dir = DIR_NONE;
      endcase
      return dir;
   endfunction

endpackage

`default_nettype wire

/* rtl/rebq_csr.sv */
// apb-style configuration register file of the encoder and button qualifier
// depends on rebq_pkg
`default_nettype none

module rebq_csr
   import rebq_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [CsrAddrWidth-1:0] paddr,
   input  wire logic [CsrDataWidth-1:0] pwdata,
   output logic      [CsrDataWidth-1:0] prdata,
   output logic                         pready,
   output cfg_type                      cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_en;

   assign index    = reg_index_type'(paddr[3:2]);
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            REG_LONG_PRESS:     cfg_in.back_hold_ms      = pwdata;
            REG_ROTARY_LOCKOUT: cfg_in.rotary_lockout_us = pwdata;
            REG_BUTTON_LOCKOUT: cfg_in.button_lockout_us = pwdata;
            REG_MIN_PRESS:      cfg_in.min_press_ms      = pwdata[MinPressWidth-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_LONG_PRESS:     prdata = cfg_ff.back_hold_ms;
         REG_ROTARY_LOCKOUT: prdata = cfg_ff.rotary_lockout_us;
         REG_BUTTON_LOCKOUT: prdata = cfg_ff.button_lockout_us;
         REG_MIN_PRESS:      prdata = {{(CsrDataWidth-MinPressWidth){1'b0}}, cfg_ff.min_press_ms};
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.back_hold_ms      <= RESET_LONG_PRESS_MS;
         cfg_ff.rotary_lockout_us <= RESET_ROTARY_LOCKOUT;
         cfg_ff.button_lockout_us <= RESET_BUTTON_LOCKOUT;
         cfg_ff.min_press_ms      <= RESET_MIN_PRESS_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/rotary_encoder_button_qualifier.sv */
// top level of the rotary encoder and push-button qualifier
// depends on rebq_pkg and rebq_csr
`default_nettype none

// Qualifies pin-change items from a quadrature encoder and a push button.
// A rotary item past the rotary lockout window that makes a valid gray step
// gives a clockwise or counter-clockwise event; a button item past the
// button lockout window tracks the press, and the release reports back
// (longer than the back hold setting, 0 meaning 500) or a short press (longer
// than min_press_ms). Each event carries time_us / 1000 as stamp_ms.
// Three register stages: the input register, a stage holding the millisecond
// stamp from a 32x29 reciprocal multiply, and the result register. State
// update happens in one stage only, so an item can be accepted every cycle
// unless rsp_stall holds the pipeline. A stalled result only holds back the
// stages behind it once they are full. The user writes configuration via the
// csr_ port only while no item is in flight; the block does not enforce this.
module rotary_encoder_button_qualifier
   import rebq_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // input items
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire req_item_type            req_data,
   // result items
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output rsp_item_type                 rsp_data,
   // configuration
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [CsrDataWidth-1:0] csr_pwdata,
   output logic      [CsrDataWidth-1:0] csr_prdata,
   output logic                         csr_pready
);

   cfg_type cfg;

   rebq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // pipeline registers
   logic                  s1_valid_ff;
   req_item_type          s1_item_ff;
   logic                  s2_valid_ff;
   req_item_type          s2_item_ff;
   logic [StampWidth-1:0] s2_ms_ff;
   logic                  rsp_valid_ff;
   rsp_item_type          rsp_data_ff;

   // qualifier state
   logic [1:0]            last_quad_ff,      last_quad_in;
   logic [TimeWidth-1:0]  last_step_us_ff,   last_step_us_in;
   logic [TimeWidth-1:0]  last_button_us_ff, last_button_us_in;
   logic                  button_down_ff,    button_down_in;
   logic [StampWidth-1:0] press_start_ms_ff, press_start_ms_in;

   // each stage moves on when the one after it is empty or moving
   logic out_free;
   logic s2_free;
   logic s1_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = !s1_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // microseconds to milliseconds, exact for every 32-bit timestamp
   logic [MsProdWidth-1:0] ms_prod;
   assign ms_prod = s1_item_ff.time_us * MS_RECIP;

   // decision stage
   logic                  s2_fire;
   logic                  emit;
   event_kind_type        kind;
   logic [1:0]            quad;
   step_dir_type          dir;
   logic [TimeWidth-1:0]  step_gap;
   logic [TimeWidth-1:0]  button_gap;
   logic [TimeWidth-1:0]  duration;
   logic [TimeWidth-1:0]  long_press;

   assign s2_fire    = s2_valid_ff && out_free;
   assign quad       = {s2_item_ff.level_a, s2_item_ff.level_b};
   assign dir        = step_dir(last_quad_ff, quad);
   assign step_gap   = s2_item_ff.time_us - last_step_us_ff;
   assign button_gap = s2_item_ff.time_us - last_button_us_ff;
   // durations wrap modulo 2^32 ms
   assign duration   = {{(TimeWidth-StampWidth){1'b0}}, s2_ms_ff}
                     - {{(TimeWidth-StampWidth){1'b0}}, press_start_ms_ff};
   assign long_press = (cfg.back_hold_ms == '0) ? DEFAULT_LONG_PRESS_MS
                                                : cfg.back_hold_ms;

   always_comb begin
      emit              = 1'b0;
      kind              = KIND_CW;
      last_quad_in      = last_quad_ff;
      last_step_us_in   = last_step_us_ff;
      last_button_us_in = last_button_us_ff;
      button_down_in    = button_down_ff;
      press_start_ms_in = press_start_ms_ff;
      if (s2_fire) begin
         if (s2_item_ff.mode == MODE_ROTARY) begin
            // outside lockout and a changed state: store it, report real steps
            if (step_gap >= cfg.rotary_lockout_us && quad != last_quad_ff) begin
               last_quad_in = quad;
               if (dir != DIR_NONE) begin
                  emit            = 1'b1;
                  kind            = (dir == DIR_FWD) ? KIND_CW : KIND_CCW;
                  last_step_us_in = s2_item_ff.time_us;
               end
            end
         end else if (button_gap >= cfg.button_lockout_us) begin
            last_button_us_in = s2_item_ff.time_us;
            if (!s2_item_ff.level_button && !button_down_ff) begin
               // press starts
               button_down_in    = 1'b1;
               press_start_ms_in = s2_ms_ff;
            end else if (s2_item_ff.level_button && button_down_ff) begin
               // release: classify by duration
               button_down_in = 1'b0;
               if (duration > long_press) begin
                  emit = 1'b1;
                  kind = KIND_BACK;
               end else if (duration > {{(TimeWidth-MinPressWidth){1'b0}}, cfg.min_press_ms}) begin
                  emit = 1'b1;
                  kind = KIND_PRESS;
               end
            end
         end
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         s2_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         last_quad_ff      <= RESET_QUADRATURE;
         last_step_us_ff   <= '0;
         last_button_us_ff <= '0;
         button_down_ff    <= 1'b0;
         press_start_ms_ff <= '0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= s2_valid_ff && emit;
         end
         last_quad_ff      <= last_quad_in;
         last_step_us_ff   <= last_step_us_in;
         last_button_us_ff <= last_button_us_in;
         button_down_ff    <= button_down_in;
         press_start_ms_ff <= press_start_ms_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_free && req_valid) begin
         s1_item_ff <= req_data;
      end
      if (s2_free && s1_valid_ff) begin
         s2_item_ff <= s1_item_ff;
         s2_ms_ff   <= ms_prod[MsShift +: StampWidth];
      end
      if (s2_fire && emit) begin
         rsp_data_ff.event_kind <= kind;
         rsp_data_ff.stamp_ms   <= s2_ms_ff;
      end
   end

endmodule

`default_nettype wire
